>>> hw/rtl/wdi_pkg.sv
package wdi_pkg;

    localparam int LETTER_W        = 5;
    localparam int DICT_DEPTH_DEF  = 1024;
    localparam int MAX_LETTERS_DEF = 7;

    localparam logic [LETTER_W-1:0] SYM_SPACE = 5'd26;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 3;

    typedef logic [2:0] state_t;

endpackage

>>> hw/rtl/word_dictionary_indexer.sv
// Word dictionary indexer. Each input beat carries one symbol (0-25 letters a-z, 26 the space
// that ends a word, 27-31 ignored) and a restart flag that empties the dictionary and the word
// buffer before the symbol is handled. A letter is taken and yields no result;
// letters past MAX_LETTERS are dropped and flagged. A space starts a linear search of the
// dictionary, held in a single-port-read memory that is scanned one entry per clock in
// insertion order, so a space keeps the block busy until the scan ends (sooner when the word is found
// early), during which s_tready stays low. The word is appended when absent and room remains.
// One result beat follows every space; the result sits in an output register, so the next
// symbol is accepted while it waits to be taken. The dictionary needs no clearing after reset.
module word_dictionary_indexer #(
    parameter int DICT_DEPTH  = wdi_pkg::DICT_DEPTH_DEF,
    parameter int MAX_LETTERS = wdi_pkg::MAX_LETTERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [4:0] symbol, [5] restart, [7:6] zero
    input  logic [wdi_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] word_index, [10] is_new, [13:11] word_length, [14] dict_full, [15] too_long
    output logic [wdi_pkg::M_TDATA_W-1:0]  m_tdata
);
    import wdi_pkg::*;

    localparam int AW     = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CW     = $clog2(DICT_DEPTH + 1);
    localparam int LC_W   = $clog2(MAX_LETTERS + 1);
    localparam int WORD_W = LETTER_W * MAX_LETTERS + LC_W;

    localparam state_t ST_IDLE = 3'd0;
    localparam state_t ST_SRCH = 3'd1;
    localparam state_t ST_FIN  = 3'd2;

    logic [LETTER_W-1:0] sym;
    logic                restart;
    logic                s_fire;

    assign sym     = s_tdata[LETTER_W-1:0];
    assign restart = s_tdata[LETTER_W];
    assign s_fire  = s_tvalid && s_tready;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LETTER_W-1:0] letters_reg [MAX_LETTERS];
    logic [LETTER_W-1:0] letters_next [MAX_LETTERS];
    logic [LC_W-1:0]     lc_reg, lc_next;
    logic                ovf_reg, ovf_next;

    logic [WORD_W-1:0]   srch_word_reg, srch_word_next;
    logic [LC_W-1:0]     srch_len_reg, srch_len_next;
    logic                srch_ovf_reg, srch_ovf_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;

    logic [AW-1:0]       res_idx_reg, res_idx_next;
    logic                res_new_reg, res_new_next;
    logic                res_full_reg, res_full_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [WORD_W-1:0]   mem [DICT_DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    logic                issue;
    logic [31:0]         idx32;
    logic [31:0]         len32;

    assign issue   = (state_reg == ST_SRCH) && (scan_reg < count_reg);
    assign rd_addr = scan_reg[AW-1:0];
    assign idx32   = 32'(res_idx_reg);
    assign len32   = 32'(srch_len_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        letters_next   = letters_reg;
        lc_next        = lc_reg;
        ovf_next       = ovf_reg;
        srch_word_next = srch_word_reg;
        srch_len_next  = srch_len_reg;
        srch_ovf_next  = srch_ovf_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (restart) begin
                        count_next = '0;
                        lc_next    = '0;
                        ovf_next   = 1'b0;
                        for (int k = 0; k < MAX_LETTERS; k++) begin
                            letters_next[k] = '0;
                        end
                    end
                    if (sym < SYM_SPACE) begin
                        if (lc_next < LC_W'(MAX_LETTERS)) begin
                            for (int k = 0; k < MAX_LETTERS; k++) begin
                                if (lc_next == LC_W'(k)) begin
                                    letters_next[k] = sym;
                                end
                            end
                            lc_next = lc_next + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else if (sym == SYM_SPACE) begin
                        srch_word_next = '0;
                        for (int k = 0; k < MAX_LETTERS; k++) begin
                            srch_word_next[k*LETTER_W +: LETTER_W] = letters_next[k];
                        end
                        srch_word_next[WORD_W-1 -: LC_W] = lc_next;
                        srch_len_next  = lc_next;
                        srch_ovf_next  = ovf_next;
                        scan_next      = '0;
                        state_next     = ST_SRCH;
                        lc_next        = '0;
                        ovf_next       = 1'b0;
                        for (int k = 0; k < MAX_LETTERS; k++) begin
                            letters_next[k] = '0;
                        end
                    end
                end
            end
            ST_SRCH: begin
                if (issue) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (cmp_vld_reg && (rd_data_reg == srch_word_reg)) begin
                    cmp_vld_next  = 1'b0;
                    res_idx_next  = cmp_idx_reg;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = ST_FIN;
                end else if (!issue && !cmp_vld_reg) begin
                    if (count_reg < CW'(DICT_DEPTH)) begin
                        wr_en         = 1'b1;
                        res_idx_next  = count_reg[AW-1:0];
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                        count_next    = count_reg + 1'b1;
                    end else begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {srch_ovf_reg, res_full_reg, len32[LENGTH_W-1:0],
                                    res_new_reg, idx32[INDEX_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= srch_word_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            lc_reg      <= '0;
            ovf_reg     <= 1'b0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_LETTERS; k++) begin
                letters_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lc_reg      <= lc_next;
            ovf_reg     <= ovf_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
            letters_reg <= letters_next;
        end
    end

    always_ff @(posedge aclk) begin
        srch_word_reg <= srch_word_next;
        srch_len_reg  <= srch_len_next;
        srch_ovf_reg  <= srch_ovf_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_idx_reg   <= res_idx_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DICT_DEPTH))
        else $error("dictionary count exceeds depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == '0))
        else $error("dictionary count moved by other than append or restart");

    a_space_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (sym == SYM_SPACE)) |=> !s_tready)
        else $error("space beat did not start a search");

    a_new_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[INDEX_W] && m_tdata[INDEX_W+LENGTH_W+1]))
        else $error("result both new and dictionary full");

    a_full_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[INDEX_W+LENGTH_W+1]) |-> (m_tdata[INDEX_W-1:0] == '0))
        else $error("full result carries a nonzero index");

endmodule
